FILE: rtl/pfla_pkg.sv
`default_nettype none

package pfla_pkg;

	localparam int unsigned ADDR_W     = 39;
	localparam int unsigned PAGE_SHIFT = 12;
	localparam int unsigned PAGE_MASK  = (1 << PAGE_SHIFT) - 1;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned CFG_IDX_W  = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_ADDR  = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		MODE_INIT  = 2'd0,
		MODE_ALLOC = 2'd1,
		MODE_FREE  = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_MEM   = 2'd1,
		STATUS_BAD_FREE = 2'd2
	} status_t;

	// Access strobes for the link memory.
	typedef struct packed {
		logic rd;
		logic wr;
	} link_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/pfla_if.sv
`default_nettype none

interface pfla_req_if;
	import pfla_pkg::*;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [ADDR_W-1:0]   address;
	modport source (output valid, output mode, output address, input ready);
	modport sink (input valid, input mode, input address, output ready);
endinterface

interface pfla_rsp_if;
	import pfla_pkg::*;
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   page_addr;
	logic [STATUS_W-1:0] status;
	modport source (output valid, output page_addr, output status, input ready);
	modport sink (input valid, input page_addr, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/page_free_list_allocator_top.sv
// Channel | Dir | Payload                        | Handshake
// req     | in  | mode[1:0], address[38:0]       | valid/ready
// rsp     | out | page_addr[38:0], status[1:0]   | valid/ready
// cfg     | in  | cfg_index[0], cfg_data[38:0]   | cfg_we, no stall
//
// One request at a time. Alloc goes ALLOC_RD, ALLOC_WB, DONE (ALLOC_RD, DONE on
// an empty list), free FREE, DONE, unused mode DONE, init INIT_SETUP, INIT_WALK,
// DONE, one link write per cycle per page. Alloc waits on the registered link read.
// The response register lets a new request in while a response is still held.
// A held response stalls only the hand-off of the following result.
// arst_n clears control state; link entries are undefined until written.
`default_nettype none

module page_free_list_allocator_top #(
	parameter int unsigned MAX_PAGES = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pfla_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfla_pkg::ADDR_W-1:0]      cfg_data,
	pfla_req_if.sink                         req,
	pfla_rsp_if.source                       rsp
);
	import pfla_pkg::*;

	localparam int unsigned IDX_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_PAGES + 1);
	localparam int unsigned LINK_W = IDX_W + 1;
	localparam int unsigned BASE_W = ADDR_W + 1;
	localparam int unsigned PNUM_W = BASE_W - PAGE_SHIFT;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT_SETUP,
		ST_INIT_WALK,
		ST_ALLOC_RD,
		ST_ALLOC_WB,
		ST_FREE,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [ADDR_W-1:0]     start_q;
	logic [ADDR_W-1:0]     stop_q;
	logic [BASE_W-1:0]     base_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [IDX_W-1:0]      head_q;
	logic                  head_valid_q;
	logic [CNT_W-1:0]      walk_q;
	logic [CNT_W-1:0]      count_q;
	logic [ADDR_W-1:0]     res_addr_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic                  rsp_valid_q;
	logic [ADDR_W-1:0]     rsp_addr_q;
	logic [STATUS_W-1:0]   rsp_status_q;

	logic [BASE_W-1:0]     start_round;
	logic [BASE_W-1:0]     init_diff;
	logic [PNUM_W-1:0]     init_pages;
	logic [CNT_W-1:0]      init_count;
	logic [BASE_W-1:0]     free_diff;
	logic [PNUM_W-1:0]     free_pnum;
	logic                  free_ok;
	logic [BASE_W-1:0]     alloc_addr;
	logic [LINK_W-1:0]     push_link;
	link_ctl_t             mem_ctl;
	logic [IDX_W-1:0]      mem_addr;
	logic [LINK_W-1:0]     mem_rd_data;
	logic                  rsp_free;

	// Configuration registers and the page-aligned base derived from start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			stop_q  <= '0;
			base_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_START_ADDR: start_q <= cfg_data;
					CFG_STOP_ADDR:  stop_q  <= cfg_data;
					default: ;
				endcase
			end
			base_q <= {start_round[BASE_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
		end
	end

	assign start_round = {1'b0, start_q} + BASE_W'(PAGE_MASK);

	// Number of whole pages between base and stop, capped at the table size.
	assign init_diff  = {1'b0, stop_q} - base_q;
	assign init_pages = init_diff[BASE_W-1:PAGE_SHIFT];
	always_comb begin
		if ({1'b0, stop_q} < base_q) begin
			init_count = '0;
		end else if (init_pages > PNUM_W'(MAX_PAGES)) begin
			init_count = CNT_W'(MAX_PAGES);
		end else begin
			init_count = init_pages[CNT_W-1:0];
		end
	end

	assign free_diff = {1'b0, addr_q} - base_q;
	assign free_pnum = free_diff[BASE_W-1:PAGE_SHIFT];
	assign free_ok   = (addr_q[PAGE_SHIFT-1:0] == '0) && (addr_q >= start_q) &&
	                   (addr_q < stop_q) && ({1'b0, addr_q} >= base_q) &&
	                   (free_pnum < PNUM_W'(MAX_PAGES));

	assign alloc_addr = base_q + (BASE_W'(head_q) << PAGE_SHIFT);

	// A pushed page links to the old head, or ends the list when it was empty.
	assign push_link = head_valid_q ? {1'b1, head_q} : '0;

	always_comb begin
		mem_ctl  = '0;
		mem_addr = head_q;
		unique case (state_q)
			ST_INIT_WALK: begin
				mem_addr   = walk_q[IDX_W-1:0];
				mem_ctl.wr = (walk_q != count_q);
			end
			ST_ALLOC_RD: begin
				mem_ctl.rd = head_valid_q;
			end
			ST_FREE: begin
				mem_addr   = free_pnum[IDX_W-1:0];
				mem_ctl.wr = free_ok;
			end
			default: ;
		endcase
	end

	pfla_link_mem #(
		.DEPTH (MAX_PAGES),
		.WIDTH (LINK_W)
	) u_link_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.addr    (mem_addr),
		.wr_data (push_link),
		.rd_data (mem_rd_data)
	);

	assign rsp_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			addr_q       <= '0;
			head_q       <= '0;
			head_valid_q <= 1'b0;
			walk_q       <= '0;
			count_q      <= '0;
			res_addr_q   <= '0;
			res_status_q <= STATUS_OK;
			rsp_valid_q  <= 1'b0;
			rsp_addr_q   <= '0;
			rsp_status_q <= STATUS_OK;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						addr_q       <= req.address;
						res_addr_q   <= '0;
						res_status_q <= STATUS_OK;
						case (req.mode)
							MODE_INIT:  state_q <= ST_INIT_SETUP;
							MODE_ALLOC: state_q <= ST_ALLOC_RD;
							MODE_FREE:  state_q <= ST_FREE;
							default:    state_q <= ST_DONE;
						endcase
					end
				end
				ST_INIT_SETUP: begin
					head_q       <= '0;
					head_valid_q <= 1'b0;
					walk_q       <= '0;
					count_q      <= init_count;
					state_q      <= ST_INIT_WALK;
				end
				ST_INIT_WALK: begin
					if (walk_q == count_q) begin
						state_q <= ST_DONE;
					end else begin
						head_q       <= walk_q[IDX_W-1:0];
						head_valid_q <= 1'b1;
						walk_q       <= walk_q + CNT_W'(1);
					end
				end
				ST_ALLOC_RD: begin
					if (head_valid_q) begin
						res_addr_q <= alloc_addr[ADDR_W-1:0];
						state_q    <= ST_ALLOC_WB;
					end else begin
						res_status_q <= STATUS_NO_MEM;
						state_q      <= ST_DONE;
					end
				end
				ST_ALLOC_WB: begin
					head_valid_q <= mem_rd_data[IDX_W];
					head_q       <= mem_rd_data[IDX_W] ? mem_rd_data[IDX_W-1:0] : '0;
					state_q      <= ST_DONE;
				end
				ST_FREE: begin
					if (free_ok) begin
						head_q       <= free_pnum[IDX_W-1:0];
						head_valid_q <= 1'b1;
					end else begin
						res_status_q <= STATUS_BAD_FREE;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_addr_q   <= res_addr_q;
						rsp_status_q <= res_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.page_addr = rsp_addr_q;
	assign rsp.status    = rsp_status_q;

endmodule

`default_nettype wire

FILE: rtl/pfla_link_mem.sv
`default_nettype none

module pfla_link_mem #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned WIDTH = 13,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  pfla_pkg::link_ctl_t  ctl,
	input  logic [AW-1:0]        addr,
	input  logic [WIDTH-1:0]     wr_data,
	output logic [WIDTH-1:0]     rd_data
);
	import pfla_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/pfla_checker.sv
`default_nettype none

module pfla_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [pfla_pkg::ADDR_W-1:0]     rsp_page_addr,
	input logic [pfla_pkg::STATUS_W-1:0]   rsp_status
);
	import pfla_pkg::*;

	// Requests are handled one at a time, so a request is never taken twice in a row.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted on two consecutive cycles");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_NO_MEM ||
		               rsp_status == STATUS_BAD_FREE))
		else $error("response status is not a defined code");

	a_error_no_page: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STATUS_OK |-> rsp_page_addr == '0)
		else $error("failed request returned a page address");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			rsp_valid && $stable(rsp_page_addr) && $stable(rsp_status))
		else $error("stalled response changed");

endmodule

bind page_free_list_allocator_top pfla_checker u_pfla_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_page_addr (rsp.page_addr),
	.rsp_status    (rsp.status)
);

`default_nettype wire
